/* src/lsr_pkg.sv */
// shared types, constants and helpers of the stencil row generator
`timescale 1ns / 1ps
`default_nettype none
package lsr_pkg;

   localparam int ROW_W     = 24;
   localparam int GRID_W    = 13;
   localparam int VAL_W     = 32;
   localparam int CSR_W     = 3;
   localparam int PLANE_W   = 2 * GRID_W;
   localparam int TOTAL_W   = 3 * GRID_W;
   localparam int WIDE_W    = VAL_W + 2;
   localparam int FRAC_BITS = 16;
   localparam longint ROW_LIMIT = 64'd16777216;
   localparam int LIMIT_W   = 31;

   // entry slots in emit order
   localparam int ENT_N    = 7;
   localparam int ENT_ZM   = 0;
   localparam int ENT_ZP   = 1;
   localparam int ENT_YM   = 2;
   localparam int ENT_YP   = 3;
   localparam int ENT_XM   = 4;
   localparam int ENT_XP   = 5;
   localparam int ENT_DIAG = 6;
   localparam int SEL_W    = 3;

   localparam logic signed [WIDE_W-1:0] ONE_Q  = WIDE_W'(1) << FRAC_BITS;
   localparam logic signed [WIDE_W-1:0] FOUR_Q = WIDE_W'(4) << FRAC_BITS;
   localparam logic signed [WIDE_W-1:0] SIX_Q  = WIDE_W'(6) << FRAC_BITS;

   // register indexes of the write port
   typedef enum logic [CSR_W-1:0] {
      CSR_GRID_X     = 3'd0,
      CSR_GRID_Y     = 3'd1,
      CSR_GRID_Z     = 3'd2,
      CSR_ALPHA_X    = 3'd3,
      CSR_ALPHA_Y    = 3'd4,
      CSR_ALPHA_Z    = 3'd5,
      CSR_DIAG_SHIFT = 3'd6
   } lsr_csr_type;

   typedef logic [ENT_N-1:0][VAL_W-1:0] lsr_vals_type;

   // decoded row handed to the emitter
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [GRID_W-1:0] k;
      logic [GRID_W-1:0] i;
      logic [GRID_W-1:0] j;
      logic              ok;
   } lsr_coord_type;

   // clamp a wide signed value to the 32-bit range
   function automatic logic [VAL_W-1:0] sat_value(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(33'sh0_7FFF_FFFF);
      lo = -(WIDE_W'(34'sh0_8000_0000));
      if (v > hi) begin
         return {1'b0, {(VAL_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(VAL_W-1){1'b0}}};
      end
      return v[VAL_W-1:0];
   endfunction

   function automatic logic signed [WIDE_W-1:0] sext_value(input logic [VAL_W-1:0] v);
      return {{(WIDE_W-VAL_W){v[VAL_W-1]}}, v};
   endfunction

endpackage
`default_nettype wire

/* src/lsr_divider.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module lsr_divider #(
   parameter int DVD_W  = 24,
   parameter int DVS_W  = 26,
   parameter int QUO_W  = 13,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire logic [DVD_W-1:0]  in_dividend,
   input  wire logic [DVS_W-1:0]  divisor,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [QUO_W-1:0]       out_quotient,
   output logic [DVD_W-1:0]       out_remainder,
   output logic [SIDE_W-1:0]      out_side
);
   localparam int CW = DVS_W + QUO_W;

   logic [QUO_W-1:0] valid_ff;
   logic [DVD_W-1:0]  rem_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int BIT = QUO_W - 1 - s;
      logic              prev_valid;
      logic [DVD_W-1:0]  prev_rem;
      logic [QUO_W-1:0]  prev_quo;
      logic [SIDE_W-1:0] prev_side;
      logic [CW-1:0]     trial;
      logic              take;
      logic [DVD_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      // stage input from the port or the stage before
      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = in_dividend;
         assign prev_quo   = '0;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_quo   = quo_ff[s-1];
         assign prev_side  = side_ff[s-1];
      end

      // trial subtract of the shifted divisor
      always_comb begin
         trial       = CW'(divisor) << BIT;
         take        = CW'(prev_rem) >= trial;
         rem_in      = take ? (prev_rem - trial[DVD_W-1:0]) : prev_rem;
         quo_in      = prev_quo;
         quo_in[BIT] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            side_ff[s] <= prev_side;
         end
      end
   end

   assign out_valid     = valid_ff[QUO_W-1];
   assign out_quotient  = quo_ff[QUO_W-1];
   assign out_remainder = rem_ff[QUO_W-1];
   assign out_side      = side_ff[QUO_W-1];
endmodule
`default_nettype wire

/* src/lsr_emitter.sv */
// walks the neighbor list of one decoded row and drives the result register
`timescale 1ns / 1ps
`default_nettype none
module lsr_emitter (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load_valid,
   input  wire lsr_pkg::lsr_coord_type load,
   output logic                       load_ready,
   input  wire logic [lsr_pkg::GRID_W-1:0]  grid_x,
   input  wire logic [lsr_pkg::GRID_W-1:0]  grid_y,
   input  wire logic [lsr_pkg::GRID_W-1:0]  grid_z,
   input  wire logic [lsr_pkg::PLANE_W-1:0] plane,
   input  wire lsr_pkg::lsr_vals_type        vals,
   output logic        rsp_tvalid,
   input  wire logic   rsp_tready,
   output logic [79:0] rsp_tdata,  // row_out, col_out, entry_value
   output logic        rsp_tuser,  // row_valid
   output logic        rsp_tlast   // last_entry
);
   import lsr_pkg::*;

   logic                 busy_ff, busy_in;
   logic [ENT_N-1:0]     mask_ff, mask_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 ok_ff, ok_in;
   logic                 valid_ff, valid_in;
   logic [79:0]          data_ff, data_in;
   logic                 user_ff, user_in;
   logic                 last_ff, last_in;

   logic                 out_free;
   logic [SEL_W-1:0]     sel;
   logic [ENT_N-1:0]     rest;
   logic                 is_last;
   logic [ROW_W-1:0]     col;
   logic [VAL_W-1:0]     value;
   logic [ENT_N-1:0]     new_mask;
   logic [GRID_W:0]      k_next, i_next, j_next;

   // lowest pending slot and what remains after it
   always_comb begin
      sel = SEL_W'(ENT_DIAG);
      for (int e = ENT_N - 1; e >= 0; e--) begin
         if (mask_ff[e]) begin
            sel = SEL_W'(e);
         end
      end
      rest      = mask_ff;
      rest[sel] = 1'b0;
      is_last   = (rest == '0);
   end

   // column and value of the selected slot
   always_comb begin
      case (sel)
         SEL_W'(ENT_ZM): col = row_ff - plane[ROW_W-1:0];
         SEL_W'(ENT_ZP): col = row_ff + plane[ROW_W-1:0];
         SEL_W'(ENT_YM): col = row_ff - ROW_W'(grid_x);
         SEL_W'(ENT_YP): col = row_ff + ROW_W'(grid_x);
         SEL_W'(ENT_XM): col = row_ff - ROW_W'(1);
         SEL_W'(ENT_XP): col = row_ff + ROW_W'(1);
         default:        col = row_ff;
      endcase
      value = vals[sel];
      if (!ok_ff) begin
         col   = '0;
         value = '0;
      end
   end

   // neighbor presence of an incoming row
   always_comb begin
      k_next = {1'b0, load.k} + 1'b1;
      i_next = {1'b0, load.i} + 1'b1;
      j_next = {1'b0, load.j} + 1'b1;
      new_mask           = '0;
      new_mask[ENT_DIAG] = 1'b1;
      if (load.ok) begin
         new_mask[ENT_ZM] = (load.k != '0);
         new_mask[ENT_ZP] = (k_next < {1'b0, grid_z});
         new_mask[ENT_YM] = (load.i != '0);
         new_mask[ENT_YP] = (i_next < {1'b0, grid_y});
         new_mask[ENT_XM] = (load.j != '0);
         new_mask[ENT_XP] = (j_next < {1'b0, grid_x});
      end
   end

   assign out_free   = !valid_ff || rsp_tready;
   assign load_ready = !busy_ff || (out_free && is_last);

   // sequencing of entries into the result register
   always_comb begin
      busy_in  = busy_ff;
      mask_in  = mask_ff;
      row_in   = row_ff;
      ok_in    = ok_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      if (busy_ff && out_free) begin
         valid_in = 1'b1;
         data_in  = {value, col, row_ff};
         user_in  = ok_ff;
         last_in  = is_last;
         mask_in  = rest;
         busy_in  = !is_last;
      end
      if (load_valid && load_ready) begin
         busy_in = 1'b1;
         mask_in = new_mask;
         row_in  = load.row;
         ok_in   = load.ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      row_ff  <= row_in;
      ok_ff   <= ok_in;
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;
endmodule
`default_nettype wire

/* src/laplacian_stencil_row_generator.sv */
// top level: register file, row decode pipeline and entry emitter
//
//  channel | direction | contents
//  req     | in        | tdata[23:0] row_in
//  rsp     | out       | tdata row_out/col_out/entry_value, tuser row_valid, tlast last_entry
//  csr     | in        | write enable, 3-bit index, 32-bit data
//
// a row passes 26 divider stages (13 for the z plane, 13 for the y line) and then
// the emitter, which sends one entry per cycle while rsp is ready: a row has up to
// seven entries, and the next row enters while the current one is sent.
// reset is synchronous and clears the registers to a 1x1x1 grid with zero terms.
// a stall on rsp freezes the whole decode pipeline; nothing is dropped or repeated.
// grid size products are registered: plane from the x and y registers, total from plane.
`timescale 1ns / 1ps
`default_nettype none
module laplacian_stencil_row_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // row_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,  // row_out, col_out, entry_value
   output logic             rsp_tuser,  // row_valid
   output logic             rsp_tlast,  // last_entry
   input  wire logic                       csr_we,
   input  wire logic [lsr_pkg::CSR_W-1:0]  csr_addr,
   input  wire logic [lsr_pkg::VAL_W-1:0]  csr_wdata
);
   import lsr_pkg::*;

   localparam int SIDE1_W = ROW_W + 1;
   localparam int SIDE2_W = GRID_W + ROW_W + 1;

   logic [GRID_W-1:0]  gx_ff, gy_ff, gz_ff;
   logic [VAL_W-1:0]   ax_ff, ay_ff, az_ff, shift_ff;
   logic [PLANE_W-1:0] plane_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic               flat_ff;
   lsr_vals_type       vals_ff, vals_in;

   logic               pipe_en;
   logic               row_ok;
   logic               d1_valid;
   logic [GRID_W-1:0]  d1_k;
   logic [ROW_W-1:0]   d1_rem;
   logic [SIDE1_W-1:0] d1_side;
   logic               d2_valid;
   logic [GRID_W-1:0]  d2_i;
   logic [ROW_W-1:0]   d2_j;
   logic [SIDE2_W-1:0] d2_side;
   lsr_coord_type      coord;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gx_ff    <= GRID_W'(1);
         gy_ff    <= GRID_W'(1);
         gz_ff    <= GRID_W'(1);
         ax_ff    <= '0;
         ay_ff    <= '0;
         az_ff    <= '0;
         shift_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GRID_X:     gx_ff    <= csr_wdata[GRID_W-1:0];
            CSR_GRID_Y:     gy_ff    <= csr_wdata[GRID_W-1:0];
            CSR_GRID_Z:     gz_ff    <= csr_wdata[GRID_W-1:0];
            CSR_ALPHA_X:    ax_ff    <= csr_wdata;
            CSR_ALPHA_Y:    ay_ff    <= csr_wdata;
            CSR_ALPHA_Z:    az_ff    <= csr_wdata;
            CSR_DIAG_SHIFT: shift_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // entry values follow the registers
   always_comb begin
      vals_in[ENT_ZM]   = sat_value(sext_value(az_ff) - ONE_Q);
      vals_in[ENT_ZP]   = sat_value(-ONE_Q - sext_value(az_ff));
      vals_in[ENT_YM]   = sat_value(sext_value(ay_ff) - ONE_Q);
      vals_in[ENT_YP]   = sat_value(-ONE_Q - sext_value(ay_ff));
      vals_in[ENT_XM]   = sat_value(sext_value(ax_ff) - ONE_Q);
      vals_in[ENT_XP]   = sat_value(-ONE_Q - sext_value(ax_ff));
      vals_in[ENT_DIAG] = sat_value((flat_ff ? FOUR_Q : SIX_Q) - sext_value(shift_ff));
   end

   // registered grid sizes: plane from x and y, total from plane and z
   always_ff @(posedge clock) begin
      plane_ff <= PLANE_W'(gx_ff) * PLANE_W'(gy_ff);
      total_ff <= TOTAL_W'(plane_ff) * TOTAL_W'(gz_ff);
      flat_ff  <= (gx_ff == GRID_W'(1)) || (gy_ff == GRID_W'(1)) || (gz_ff == GRID_W'(1));
      vals_ff  <= vals_in;
   end

   assign row_ok     = (TOTAL_W'(req_tdata) < total_ff)
                    && (LIMIT_W'(req_tdata) < LIMIT_W'(ROW_LIMIT));
   assign req_tready = pipe_en;

   // z plane split
   lsr_divider #(
      .DVD_W (ROW_W),
      .DVS_W (PLANE_W),
      .QUO_W (GRID_W),
      .SIDE_W(SIDE1_W)
   ) u_div_plane (
      .clock        (clock),
      .reset        (reset),
      .enable       (pipe_en),
      .in_valid     (req_tvalid),
      .in_dividend  (req_tdata),
      .divisor      (plane_ff),
      .in_side      ({row_ok, req_tdata}),
      .out_valid    (d1_valid),
      .out_quotient (d1_k),
      .out_remainder(d1_rem),
      .out_side     (d1_side)
   );

   // y line split
   lsr_divider #(
      .DVD_W (ROW_W),
      .DVS_W (GRID_W),
      .QUO_W (GRID_W),
      .SIDE_W(SIDE2_W)
   ) u_div_line (
      .clock        (clock),
      .reset        (reset),
      .enable       (pipe_en),
      .in_valid     (d1_valid),
      .in_dividend  (d1_rem),
      .divisor      (gx_ff),
      .in_side      ({d1_k, d1_side}),
      .out_valid    (d2_valid),
      .out_quotient (d2_i),
      .out_remainder(d2_j),
      .out_side     (d2_side)
   );

   always_comb begin
      coord.row = d2_side[ROW_W-1:0];
      coord.ok  = d2_side[ROW_W];
      coord.k   = d2_side[SIDE2_W-1:ROW_W+1];
      coord.i   = d2_i;
      coord.j   = d2_j[GRID_W-1:0];
   end

   lsr_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load_valid(d2_valid),
      .load      (coord),
      .load_ready(pipe_en),
      .grid_x    (gx_ff),
      .grid_y    (gy_ff),
      .grid_z    (gz_ff),
      .plane     (plane_ff),
      .vals      (vals_ff),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );
endmodule
`default_nettype wire
